### rtl/core/cube_map_texel_lookup_unit_macros.svh
// ----------------------------------------------------------------------------
// cube map texel lookup assertion macros
// shared property wrappers for the checker, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_TEXEL_LOOKUP_UNIT_MACROS_SVH
`define CUBE_MAP_TEXEL_LOOKUP_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define CMTL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define CMTL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/cmtl_pkg.sv
// ----------------------------------------------------------------------------
// cmtl_pkg
// types, field layout and constants of the cube map texel lookup unit
// ----------------------------------------------------------------------------
package cmtl_pkg;

	localparam int MAX_FACE_WIDTH_DEF = 64;
	localparam int MAX_CHANNELS_DEF   = 4;
	localparam int FACE_COUNT         = 6;

	localparam int FW_W       = 7;
	localparam int CH_W       = 3;
	localparam int DIR_W      = 16;
	localparam int MAG_W      = 16;
	localparam int NUM_W      = 17;
	localparam int PROD_W     = FW_W + NUM_W;
	localparam int Q_W        = FW_W;
	localparam int FACE_W     = 3;
	localparam int COORD_W    = 6;
	localparam int TEXEL_W    = 32;
	localparam int USER_W     = 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [FW_W-1:0] FACE_WIDTH_RESET    = FW_W'(64);
	localparam logic [CH_W-1:0] CHANNEL_COUNT_RESET = CH_W'(3);

	// request field offsets in s_tdata
	localparam int IN_TDATA_W = 96;
	localparam int DX_LSB     = 0;
	localparam int DY_LSB     = DX_LSB + DIR_W;
	localparam int DZ_LSB     = DY_LSB + DIR_W;
	localparam int LF_LSB     = DZ_LSB + DIR_W;
	localparam int LC_LSB     = LF_LSB + FACE_W;
	localparam int LR_LSB     = LC_LSB + COORD_W;
	localparam int LT_LSB     = LR_LSB + COORD_W;

	// result field offsets in m_tdata
	localparam int OUT_TDATA_W = 48;
	localparam int OF_LSB      = 0;
	localparam int OC_LSB      = OF_LSB + FACE_W;
	localparam int OR_LSB      = OC_LSB + COORD_W;
	localparam int OT_LSB      = OR_LSB + COORD_W;
	localparam int OUT_USED_W  = OT_LSB + TEXEL_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FACE_WIDTH    = 1'b0,
		REG_CHANNEL_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic [FACE_W-1:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_POS_Y = 3'd2,
		FACE_NEG_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	// projection of one direction onto its major face
	typedef struct packed {
		face_t            face;
		logic             zero;
		logic [MAG_W-1:0] mag;
		logic [NUM_W-1:0] num_u;
		logic [NUM_W-1:0] num_v;
	} proj_t;

	typedef struct packed {
		logic [TEXEL_W-1:0] texel;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		face_t              face;
		logic               zero;
	} result_t;

endpackage

### rtl/core/cube_map_texel_lookup_unit.sv
// query path to m_tvalid: s1, s2, s3, divider stages, s11, store read (s12), output register
// throughput: one request per cycle unless stalled, loads and queries mixed, single ram port
// the two 7-stage dividers and the ram share one pipeline enable; loads write in stream order
// reset: face_width 64, channel_count 3, pipeline and output buffers empty
// reset leaves the texel store untouched; its contents are undefined until loaded
// ----------------------------------------------------------------------------
// cube_map_texel_lookup_unit
// cube face selection, texel addressing and texel fetch from a six face store
// ----------------------------------------------------------------------------
module cube_map_texel_lookup_unit #(
	parameter int MAX_FACE_WIDTH = cmtl_pkg::MAX_FACE_WIDTH_DEF,
	parameter int MAX_CHANNELS   = cmtl_pkg::MAX_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// dir_x, dir_y, dir_z, load_face, load_col, load_row, load_texel, zero pad
	input  logic [cmtl_pkg::IN_TDATA_W-1:0]     s_tdata,
	// kind
	input  logic [cmtl_pkg::USER_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// face, col, row, texel, zero pad
	output logic [cmtl_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// zero_direction
	output logic [cmtl_pkg::USER_W-1:0]         m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cmtl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cmtl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cmtl_pkg::*;

	localparam int STORE_DEPTH = FACE_COUNT * MAX_FACE_WIDTH * MAX_FACE_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DIV_STEPS   = Q_W;
	localparam logic [ADDR_W-1:0] FACE_STRIDE = ADDR_W'(MAX_FACE_WIDTH * MAX_FACE_WIDTH);
	localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(MAX_FACE_WIDTH);

	typedef struct packed {
		kind_t               kind;
		face_t               face;
		logic                zero;
		logic                wr_ok;
		logic [ADDR_W-1:0]   load_addr;
		logic [TEXEL_W-1:0]  load_texel;
	} side_t;

	// configuration
	logic [FW_W-1:0] face_width_q;
	logic [CH_W-1:0] channel_count_q;
	logic [FW_W-1:0] w_eff, w_max;
	logic [CH_W-1:0] ch_eff;
	logic [TEXEL_W-1:0] ch_mask;

	// pipeline
	logic                     adv;
	logic                     valid_s1, valid_s2, valid_s3, valid_s11, valid_s12;
	kind_t                    kind_s1;
	logic signed [DIR_W-1:0]  dir_x_s1, dir_y_s1, dir_z_s1;
	logic [FACE_W-1:0]        load_face_s1;
	logic [COORD_W-1:0]       load_col_s1, load_row_s1;
	logic [TEXEL_W-1:0]       load_texel_s1;
	proj_t                    proj;
	logic                     wr_ok;
	logic [ADDR_W-1:0]        load_addr;
	logic [MAG_W-1:0]         mag_s2;
	logic [NUM_W-1:0]         num_u_s2, num_v_s2;
	side_t                    side_s2, side_s3;
	logic [PROD_W-1:0]        prod_u_s3, prod_v_s3;
	logic [NUM_W-1:0]         dvs_s3;
	logic [DIV_STEPS-1:0]     valid_dv_s;
	side_t                    side_dv_s [DIV_STEPS];
	side_t                    side_end;
	logic [Q_W-1:0]           q_col, q_row, col_c, row_c;
	logic [ADDR_W-1:0]        query_addr;
	kind_t                    kind_s11, kind_s12;
	logic                     we_s11;
	logic [ADDR_W-1:0]        addr_s11;
	logic [TEXEL_W-1:0]       wdata_s11;
	face_t                    face_s11, face_s12;
	logic [COORD_W-1:0]       col_s11, row_s11, col_s12, row_s12;
	logic                     zero_s11, zero_s12;
	logic [TEXEL_W-1:0]       rdata;

	// output register with skid
	logic    push;
	result_t new_out, out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_width_q    <= FACE_WIDTH_RESET;
			channel_count_q <= CHANNEL_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FACE_WIDTH: begin
					face_width_q <= cfg_data[FW_W-1:0];
				end
				REG_CHANNEL_COUNT: begin
					channel_count_q <= cfg_data[CH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (face_width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (int'(face_width_q) > MAX_FACE_WIDTH) begin
			w_eff = FW_W'(MAX_FACE_WIDTH);
		end else begin
			w_eff = face_width_q;
		end
		w_max = w_eff - 1'b1;
		if (channel_count_q == '0) begin
			ch_eff = CH_W'(1);
		end else if (int'(channel_count_q) > MAX_CHANNELS) begin
			ch_eff = CH_W'(MAX_CHANNELS);
		end else begin
			ch_eff = channel_count_q;
		end
		for (int b = 0; b < TEXEL_W / 8; b++) begin
			ch_mask[b*8 +: 8] = (b < int'(ch_eff)) ? 8'hFF : 8'h00;
		end
	end

	// ---------------- s1: request capture ----------------
	assign adv      = !skid_valid_q;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			kind_s1       <= kind_t'(s_tuser[0]);
			dir_x_s1      <= s_tdata[DX_LSB +: DIR_W];
			dir_y_s1      <= s_tdata[DY_LSB +: DIR_W];
			dir_z_s1      <= s_tdata[DZ_LSB +: DIR_W];
			load_face_s1  <= s_tdata[LF_LSB +: FACE_W];
			load_col_s1   <= s_tdata[LC_LSB +: COORD_W];
			load_row_s1   <= s_tdata[LR_LSB +: COORD_W];
			load_texel_s1 <= s_tdata[LT_LSB +: TEXEL_W];
		end
	end

	cmtl_face_select u_face_select (
		.dir_x (dir_x_s1),
		.dir_y (dir_y_s1),
		.dir_z (dir_z_s1),
		.proj  (proj)
	);

	// loads outside the store are dropped
	assign wr_ok = (int'(load_face_s1) < FACE_COUNT) && (int'(load_col_s1) < MAX_FACE_WIDTH)
		&& (int'(load_row_s1) < MAX_FACE_WIDTH);
	assign load_addr = FACE_STRIDE * ADDR_W'(load_face_s1) + ROW_STRIDE * ADDR_W'(load_row_s1)
		+ ADDR_W'(load_col_s1);

	// ---------------- s2 / s3: projection, width scaling ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s2             <= proj.mag;
			num_u_s2           <= proj.num_u;
			num_v_s2           <= proj.num_v;
			side_s2.kind       <= kind_s1;
			side_s2.face       <= proj.face;
			side_s2.zero       <= proj.zero;
			side_s2.wr_ok      <= wr_ok;
			side_s2.load_addr  <= load_addr;
			side_s2.load_texel <= load_texel_s1;
			prod_u_s3          <= PROD_W'(w_eff) * PROD_W'(num_u_s2);
			prod_v_s3          <= PROD_W'(w_eff) * PROD_W'(num_v_s2);
			dvs_s3             <= {mag_s2, 1'b0};
			side_s3            <= side_s2;
		end
	end

	// ---------------- s4 .. s10: division by 2m ----------------
	cmtl_divider #(.DW(PROD_W), .VW(NUM_W), .QW(Q_W)) u_div_col (
		.clk      (clk),
		.en       (adv),
		.dividend (prod_u_s3),
		.divisor  (dvs_s3),
		.quotient (q_col)
	);

	cmtl_divider #(.DW(PROD_W), .VW(NUM_W), .QW(Q_W)) u_div_row (
		.clk      (clk),
		.en       (adv),
		.dividend (prod_v_s3),
		.divisor  (dvs_s3),
		.quotient (q_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_dv_s <= '0;
		end else if (adv) begin
			valid_dv_s <= {valid_dv_s[DIV_STEPS-2:0], valid_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_dv_s[0] <= side_s3;
			for (int i = 1; i < DIV_STEPS; i++) begin
				side_dv_s[i] <= side_dv_s[i-1];
			end
		end
	end

	assign side_end = side_dv_s[DIV_STEPS-1];

	// ---------------- s11: clamp and store address ----------------
	assign col_c = (q_col > w_max) ? w_max : q_col;
	assign row_c = (q_row > w_max) ? w_max : q_row;
	assign query_addr = FACE_STRIDE * ADDR_W'(side_end.face) + ROW_STRIDE * ADDR_W'(row_c)
		+ ADDR_W'(col_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
		end else if (adv) begin
			valid_s11 <= valid_dv_s[DIV_STEPS-1];
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s11  <= side_end.kind;
			we_s11    <= (side_end.kind == KIND_LOAD) && side_end.wr_ok;
			addr_s11  <= (side_end.kind == KIND_LOAD) ? side_end.load_addr : query_addr;
			wdata_s11 <= side_end.load_texel;
			face_s11  <= side_end.face;
			col_s11   <= col_c[COORD_W-1:0];
			row_s11   <= row_c[COORD_W-1:0];
			zero_s11  <= side_end.zero;
			kind_s12  <= kind_s11;
			face_s12  <= face_s11;
			col_s12   <= col_s11;
			row_s12   <= row_s11;
			zero_s12  <= zero_s11;
		end
	end

	// ---------------- s12: store access ----------------
	cmtl_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_texel_store (
		.clk   (clk),
		.en    (adv && valid_s11),
		.we    (we_s11),
		.addr  (addr_s11),
		.wdata (wdata_s11),
		.rdata (rdata)
	);

	// ---------------- output ----------------
	assign push = adv && valid_s12 && (kind_s12 == KIND_QUERY);

	always_comb begin
		new_out = '0;
		if (zero_s12) begin
			new_out.zero = 1'b1;
		end else begin
			new_out.face  = face_s12;
			new_out.col   = col_s12;
			new_out.row   = row_s12;
			new_out.texel = rdata & ch_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : new_out;
		end else if (push) begin
			skid_q <= new_out;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, out_q.texel, out_q.row, out_q.col,
		out_q.face};
	assign m_tuser  = out_q.zero;

endmodule

### rtl/core/cmtl_ram.sv
// ----------------------------------------------------------------------------
// cmtl_ram
// single port synchronous ram, one access per cycle, registered read
// ----------------------------------------------------------------------------
module cmtl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 24576
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/core/cmtl_face_select.sv
// ----------------------------------------------------------------------------
// cmtl_face_select
// major axis pick and projection numerators for one direction
// ----------------------------------------------------------------------------
module cmtl_face_select (
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_x,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_y,
	input  logic signed [cmtl_pkg::DIR_W-1:0] dir_z,
	output cmtl_pkg::proj_t                   proj
);
	import cmtl_pkg::*;

	function automatic logic [MAG_W-1:0] magnitude(input logic [DIR_W-1:0] d);
		return d[DIR_W-1] ? (~d + 1'b1) : d;
	endfunction

	logic [MAG_W-1:0]       ax, ay, az;
	logic signed [NUM_W:0]  xs, ys, zs, ms, us, vs;
	logic                   x_major, y_major;

	assign ax = magnitude(dir_x);
	assign ay = magnitude(dir_y);
	assign az = magnitude(dir_z);
	assign xs = {{(NUM_W+1-DIR_W){dir_x[DIR_W-1]}}, dir_x};
	assign ys = {{(NUM_W+1-DIR_W){dir_y[DIR_W-1]}}, dir_y};
	assign zs = {{(NUM_W+1-DIR_W){dir_z[DIR_W-1]}}, dir_z};

	always_comb begin
		// ties go to x, then y
		x_major = (ax >= ay) && (ax >= az);
		y_major = !x_major && (ay >= az);
		proj.zero = ((ax | ay | az) == '0);
		if (x_major) begin
			proj.mag = ax;
		end else if (y_major) begin
			proj.mag = ay;
		end else begin
			proj.mag = az;
		end
		ms = {{(NUM_W+1-MAG_W){1'b0}}, proj.mag};
		if (x_major) begin
			if (!dir_x[DIR_W-1]) begin
				proj.face = FACE_POS_X;
				us = ms - zs;
			end else begin
				proj.face = FACE_NEG_X;
				us = ms + zs;
			end
			vs = ms - ys;
		end else if (y_major) begin
			us = ms + xs;
			if (!dir_y[DIR_W-1]) begin
				proj.face = FACE_POS_Y;
				vs = ms + zs;
			end else begin
				proj.face = FACE_NEG_Y;
				vs = ms - zs;
			end
		end else begin
			if (!dir_z[DIR_W-1]) begin
				proj.face = FACE_POS_Z;
				us = ms + xs;
			end else begin
				proj.face = FACE_NEG_Z;
				us = ms - xs;
			end
			vs = ms - ys;
		end
		// numerators lie in 0 .. 2m
		proj.num_u = us[NUM_W-1:0];
		proj.num_v = vs[NUM_W-1:0];
	end

endmodule

### rtl/core/cmtl_divider.sv
// ----------------------------------------------------------------------------
// cmtl_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cmtl_divider #(
	parameter int DW = cmtl_pkg::PROD_W,
	parameter int VW = cmtl_pkg::NUM_W,
	parameter int QW = cmtl_pkg::Q_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [QW-1:0] quotient
);

	// dividend must stay below divisor << QW
	logic [DW-1:0] rem_s [QW-1];
	logic [VW-1:0] dvs_s [QW-1];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_in;
		logic [DW-1:0] sub;
		logic [VW-1:0] dvs_in;
		logic [QW-1:0] quo_in;
		logic          fits;

		if (k == 0) begin : g_first
			assign rem_in = dividend;
			assign dvs_in = divisor;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign sub  = DW'(dvs_in) << (QW - 1 - k);
		assign fits = (rem_in >= sub);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_in | (QW'(fits) << (QW - 1 - k));
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= fits ? (rem_in - sub) : rem_in;
					dvs_s[k] <= dvs_in;
				end
			end
		end
	end

	assign quotient = quo_s[QW-1];

endmodule

### rtl/core/cmtl_checker.sv
// ----------------------------------------------------------------------------
// cmtl_checker
// port level checks of the cube map texel lookup unit, bound to the top
// ----------------------------------------------------------------------------
`include "cube_map_texel_lookup_unit_macros.svh"

module cmtl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [cmtl_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic [cmtl_pkg::USER_W-1:0]       m_tuser
);
	import cmtl_pkg::*;

	// a zero direction result carries no face, coordinates or texel
	`CMTL_ASSERT_NOW(a_zero_dir_clear, m_tvalid && m_tuser[0], m_tdata == '0, "zero direction result has nonzero fields")

	`CMTL_ASSERT_NOW(a_face_range, m_tvalid, m_tdata[OF_LSB +: FACE_W] < FACE_W'(FACE_COUNT), "face code out of range")

	// input side only stalls behind a held result
	`CMTL_ASSERT_NOW(a_ready_after_stall, !s_tready, $past(m_tvalid && !m_tready), "s_tready low without output stall")

	`CMTL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind cube_map_texel_lookup_unit cmtl_checker u_cmtl_checker (.*);
